@@ design/rgbyuv_pkg.sv @@
package rgbyuv_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_CHROMA_LAYOUT   = 2'd2;
    localparam logic [1:0] REG_ROUNDING_ENABLE = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    // Register reset values
    localparam logic [12:0] RESET_WIDTH    = 13'd720;
    localparam logic [12:0] RESET_HEIGHT   = 13'd1280;
    localparam logic        RESET_LAYOUT   = 1'b0;
    localparam logic        RESET_ROUNDING = 1'b1;

    // Chroma layout codes
    localparam logic LAYOUT_NV12 = 1'b0;
    localparam logic LAYOUT_I420 = 1'b1;

    localparam int LUMA_ADDR_W   = 24;
    localparam int CHROMA_ADDR_W = 25;
    localparam int CHROMA_CNT_W  = 22;

    // Queue between the front and the back part
    localparam int QDEPTH = 2;
    localparam int QPW    = 1;

    // BT.601 studio-range coefficients, Q8
    localparam int SUM_W = 18;
    localparam logic signed [SUM_W-1:0] Y_R = 18'sd66;
    localparam logic signed [SUM_W-1:0] Y_G = 18'sd129;
    localparam logic signed [SUM_W-1:0] Y_B = 18'sd25;
    localparam logic signed [SUM_W-1:0] U_R = -18'sd38;
    localparam logic signed [SUM_W-1:0] U_G = -18'sd74;
    localparam logic signed [SUM_W-1:0] U_B = 18'sd112;
    localparam logic signed [SUM_W-1:0] V_R = 18'sd112;
    localparam logic signed [SUM_W-1:0] V_G = -18'sd94;
    localparam logic signed [SUM_W-1:0] V_B = -18'sd18;
    localparam logic signed [SUM_W-1:0] ROUND_BIAS = 18'sd128;
    localparam logic [10:0] LUMA_OFFSET   = 11'd16;
    localparam logic [10:0] CHROMA_OFFSET = 11'd128;

    typedef struct packed {
        logic                   write;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_t;

    typedef struct packed {
        logic [7:0]               luma_value;
        logic [LUMA_ADDR_W-1:0]   luma_address;
        logic                     chroma_valid;
        logic [7:0]               blue_diff_value;
        logic [7:0]               red_diff_value;
        logic [CHROMA_ADDR_W-1:0] blue_diff_address;
        logic [CHROMA_ADDR_W-1:0] red_diff_address;
        logic                     frame_end;
    } res_t;

    // One classified pixel waiting for the color math
    typedef struct packed {
        pix_t                     pix;
        logic                     round;
        logic                     chroma;
        logic [LUMA_ADDR_W-1:0]   luma_address;
        logic [CHROMA_ADDR_W-1:0] blue_diff_address;
        logic [CHROMA_ADDR_W-1:0] red_diff_address;
        logic                     frame_end;
    } work_t;

endpackage

@@ design/rgbyuv_front.sv @@
module rgbyuv_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rgbyuv_pkg::cfg_t    cfg,
    input  logic                pixel_valid,
    input  rgbyuv_pkg::pix_t    pixel,
    input  logic                q_full,
    output logic                pixel_stall,
    output logic                push,
    output rgbyuv_pkg::work_t   item
);

    localparam int DIMW = $clog2(MAX_WIDTH + 1);
    localparam int DIMH = $clog2(MAX_HEIGHT + 1);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int FW   = DIMW + DIMH;
    localparam int QW   = FW - 2;
    localparam int AW   = rgbyuv_pkg::CHROMA_ADDR_W;
    localparam int LW   = rgbyuv_pkg::LUMA_ADDR_W;
    localparam int KW   = rgbyuv_pkg::CHROMA_CNT_W;

    // Clamp to 2..maxv, then round down to even
    function automatic logic [13:0] fit_size(input logic [12:0] v, input logic [13:0] maxv);
        logic [13:0] t;
        t = {1'b0, v};
        if (t < 14'd2)
            t = 14'd2;
        if (t > maxv)
            t = maxv;
        return t & ~14'd1;
    endfunction

    localparam logic [DIMW-1:0] RST_W =
        DIMW'(fit_size(rgbyuv_pkg::RESET_WIDTH, 14'(MAX_WIDTH)));
    localparam logic [DIMH-1:0] RST_H =
        DIMH'(fit_size(rgbyuv_pkg::RESET_HEIGHT, 14'(MAX_HEIGHT)));
    localparam logic [FW-1:0] RST_F = FW'(RST_W) * FW'(RST_H);
    localparam logic [QW-1:0] RST_Q = QW'(RST_W >> 1) * QW'(RST_H >> 1);

    logic [DIMW-1:0] width_reg,   width_next;
    logic [DIMH-1:0] height_reg,  height_next;
    logic [FW-1:0]   frame_reg,   frame_next;
    logic [QW-1:0]   quarter_reg, quarter_next;
    logic            layout_reg,  layout_next;
    logic            round_reg,   round_next;
    logic [CW-1:0]   col_reg,     col_next;
    logic [RW-1:0]   row_reg,     row_next;
    logic [LW-1:0]   luma_ptr_reg, luma_ptr_next;
    logic [KW-1:0]   chroma_cnt_reg, chroma_cnt_next;

    logic            size_write;
    logic [DIMW-1:0] fit_w;
    logic [DIMH-1:0] fit_h;
    logic [DIMW-1:0] mul_w;
    logic [DIMH-1:0] mul_h;
    logic            col_last;
    logic            row_last;
    logic            last;
    logic            chroma;
    logic [AW-1:0]   frame_a;
    logic [AW-1:0]   k_a;

    assign pixel_stall = q_full;
    assign push        = pixel_valid && !q_full;

    assign fit_w = DIMW'(fit_size(cfg.data, 14'(MAX_WIDTH)));
    assign fit_h = DIMH'(fit_size(cfg.data, 14'(MAX_HEIGHT)));

    // Classify the current pixel
    assign col_last = (DIMW'(col_reg) + DIMW'(1)) >= width_reg;
    assign row_last = (DIMH'(row_reg) + DIMH'(1)) >= height_reg;
    assign last     = col_last && row_last;
    assign chroma   = !col_reg[0] && !row_reg[0];
    assign frame_a  = AW'(frame_reg);
    assign k_a      = AW'(chroma_cnt_reg);

    always_comb
    begin
        item.pix          = pixel;
        item.round        = round_reg;
        item.chroma       = chroma;
        item.luma_address = luma_ptr_reg;
        item.frame_end    = last;
        item.blue_diff_address = '0;
        item.red_diff_address  = '0;
        if (chroma)
        begin
            if (layout_reg == rgbyuv_pkg::LAYOUT_I420)
            begin
                item.blue_diff_address = frame_a + k_a;
                item.red_diff_address  = frame_a + AW'(quarter_reg) + k_a;
            end
            else
            begin
                item.blue_diff_address = frame_a + {k_a[AW-2:0], 1'b0};
                item.red_diff_address  = frame_a + {k_a[AW-2:0], 1'b1};
            end
        end
    end

    always_comb
    begin
        width_next      = width_reg;
        height_next     = height_reg;
        layout_next     = layout_reg;
        round_next      = round_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        luma_ptr_next   = luma_ptr_reg;
        chroma_cnt_next = chroma_cnt_reg;
        size_write      = 1'b0;

        if (cfg.write)
        begin
            unique case (cfg.index)
                rgbyuv_pkg::REG_IMAGE_WIDTH:
                begin
                    width_next = fit_w;
                    size_write = 1'b1;
                end
                rgbyuv_pkg::REG_IMAGE_HEIGHT:
                begin
                    height_next = fit_h;
                    size_write  = 1'b1;
                end
                rgbyuv_pkg::REG_CHROMA_LAYOUT:   layout_next = cfg.data[0];
                rgbyuv_pkg::REG_ROUNDING_ENABLE: round_next  = cfg.data[0];
                default: ;
            endcase
        end

        if (size_write)
        begin
            col_next        = '0;
            row_next        = '0;
            luma_ptr_next   = '0;
            chroma_cnt_next = '0;
        end
        else if (push)
        begin
            if (chroma)
                chroma_cnt_next = chroma_cnt_reg + KW'(1);
            if (last)
            begin
                col_next        = '0;
                row_next        = '0;
                luma_ptr_next   = '0;
                chroma_cnt_next = '0;
            end
            else
            begin
                luma_ptr_next = luma_ptr_reg + LW'(1);
                if (col_last)
                begin
                    col_next = '0;
                    row_next = row_reg + RW'(1);
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end
        end
    end

    // Frame size and quarter size follow the new dimensions
    assign mul_w        = width_next;
    assign mul_h        = height_next;
    assign frame_next   = FW'(mul_w) * FW'(mul_h);
    assign quarter_next = QW'(mul_w >> 1) * QW'(mul_h >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= RST_W;
            height_reg     <= RST_H;
            frame_reg      <= RST_F;
            quarter_reg    <= RST_Q;
            layout_reg     <= rgbyuv_pkg::RESET_LAYOUT;
            round_reg      <= rgbyuv_pkg::RESET_ROUNDING;
            col_reg        <= '0;
            row_reg        <= '0;
            luma_ptr_reg   <= '0;
            chroma_cnt_reg <= '0;
        end
        else
        begin
            width_reg      <= width_next;
            height_reg     <= height_next;
            if (size_write)
            begin
                frame_reg   <= frame_next;
                quarter_reg <= quarter_next;
            end
            layout_reg     <= layout_next;
            round_reg      <= round_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            luma_ptr_reg   <= luma_ptr_next;
            chroma_cnt_reg <= chroma_cnt_next;
        end
    end

endmodule

@@ design/rgbyuv_queue.sv @@
module rgbyuv_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rgbyuv_pkg::work_t   item_in,
    input  logic                pop,
    output rgbyuv_pkg::work_t   item_out,
    output logic                full,
    output logic                not_empty
);

    localparam int PW = rgbyuv_pkg::QPW;

    rgbyuv_pkg::work_t mem_reg [rgbyuv_pkg::QDEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg,  count_next;

    assign item_out  = mem_reg[rd_ptr_reg];
    assign full      = count_reg == (PW + 1)'(rgbyuv_pkg::QDEPTH);
    assign not_empty = count_reg != '0;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + (PW + 1)'(push) - (PW + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= item_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ design/rgbyuv_back.sv @@
module rgbyuv_back (
    input  logic                clk,
    input  logic                rst_n,
    input  rgbyuv_pkg::work_t   head,
    input  logic                q_valid,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_stall,
    output rgbyuv_pkg::res_t    result
);

    localparam int SW = rgbyuv_pkg::SUM_W;

    // Optional rounding, floor shift, add offset, clamp to a byte
    function automatic logic [7:0] to_byte(input logic signed [SW-1:0] sum,
                                           input logic round,
                                           input logic [10:0] offset);
        logic signed [SW-1:0] bias;
        logic signed [SW-1:0] t;
        logic [10:0]          v;
        bias = round ? rgbyuv_pkg::ROUND_BIAS : '0;
        t = (sum + bias) >>> 8;
        v = t[10:0] + offset;
        if (v[10])
            return 8'd0;
        else if (v[9:8] != 2'b00)
            return 8'd255;
        else
            return v[7:0];
    endfunction

    logic                  take;
    logic                  valid_reg, valid_next;
    rgbyuv_pkg::res_t      out_reg,   out_next;
    logic signed [SW-1:0]  r_s, g_s, b_s;
    logic signed [SW-1:0]  y_sum, u_sum, v_sum;

    assign take         = !valid_reg || !result_stall;
    assign pop          = q_valid && take;
    assign result_valid = valid_reg;
    assign result       = out_reg;

    assign r_s = signed'({{(SW - 8){1'b0}}, head.pix.red});
    assign g_s = signed'({{(SW - 8){1'b0}}, head.pix.green});
    assign b_s = signed'({{(SW - 8){1'b0}}, head.pix.blue});

    assign y_sum = rgbyuv_pkg::Y_R * r_s + rgbyuv_pkg::Y_G * g_s + rgbyuv_pkg::Y_B * b_s;
    assign u_sum = rgbyuv_pkg::U_R * r_s + rgbyuv_pkg::U_G * g_s + rgbyuv_pkg::U_B * b_s;
    assign v_sum = rgbyuv_pkg::V_R * r_s + rgbyuv_pkg::V_G * g_s + rgbyuv_pkg::V_B * b_s;

    always_comb
    begin
        valid_next = valid_reg;
        out_next   = out_reg;
        if (take)
            valid_next = q_valid;
        if (pop)
        begin
            out_next.luma_value        = to_byte(y_sum, head.round, rgbyuv_pkg::LUMA_OFFSET);
            out_next.luma_address      = head.luma_address;
            out_next.chroma_valid      = head.chroma;
            out_next.blue_diff_value   = '0;
            out_next.red_diff_value    = '0;
            out_next.blue_diff_address = head.blue_diff_address;
            out_next.red_diff_address  = head.red_diff_address;
            out_next.frame_end         = head.frame_end;
            if (head.chroma)
            begin
                out_next.blue_diff_value =
                    to_byte(u_sum, head.round, rgbyuv_pkg::CHROMA_OFFSET);
                out_next.red_diff_value  =
                    to_byte(v_sum, head.round, rgbyuv_pkg::CHROMA_OFFSET);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

endmodule

@@ design/rgb_to_yuv420_converter.sv @@
// Channel   Direction  Handshake                     Payload
// pixel     in         pixel_valid / pixel_stall     red, green, blue
// result    out        result_valid / result_stall   Y, U, V bytes and addresses, flags
// cfg       in         cfg_write                     cfg_index, cfg_data
//
// Sustains one pixel per clock while result_stall is low. An accepted pixel passes
// through the two-entry queue into the single color-math register stage, the result
// register, and is shown there until taken.
// rst_n clears counters, queue and result valid, and loads the register defaults.
// pixel_stall rises only when both queue entries are held by a stalled result.
module rgb_to_yuv420_converter #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_write,
    input  logic [rgbyuv_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [rgbyuv_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                     pixel_valid,
    output logic                                     pixel_stall,
    input  rgbyuv_pkg::pix_t                         pixel,
    output logic                                     result_valid,
    input  logic                                     result_stall,
    output rgbyuv_pkg::res_t                         result
);

    rgbyuv_pkg::cfg_t  cfg;
    rgbyuv_pkg::work_t q_in;
    rgbyuv_pkg::work_t q_head;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_valid;

    assign cfg.write = cfg_write;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // Front: hold frame geometry and counters, classify and address each pixel
    rgbyuv_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .pixel_valid (pixel_valid),
        .pixel       (pixel),
        .q_full      (q_full),
        .pixel_stall (pixel_stall),
        .push        (push),
        .item        (q_in)
    );

    // Queue: decouple classification from the color math and output stall
    rgbyuv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item_in   (q_in),
        .pop       (pop),
        .item_out  (q_head),
        .full      (q_full),
        .not_empty (q_valid)
    );

    // Back: convert to Y/U/V, clamp, and hold the result until taken
    rgbyuv_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .q_valid      (q_valid),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ design/rgbyuv_checker.sv @@
module rgbyuv_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              result_valid,
    input  logic              result_stall,
    input  rgbyuv_pkg::res_t  result
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // Drop chroma fields to zero when no sample is carried
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.chroma_valid |->
            result.blue_diff_value == '0 && result.red_diff_value == '0 &&
            result.blue_diff_address == '0 && result.red_diff_address == '0)
        else $error("chroma fields set without a sample");

    // Chroma sites sit on even columns of even-width rows
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.chroma_valid |-> !result.luma_address[0])
        else $error("chroma sample on an odd luma address");

    // The last pixel is in an odd column, so it carries no chroma
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.frame_end |-> !result.chroma_valid)
        else $error("frame end with a chroma sample");

endmodule

bind rgb_to_yuv420_converter rgbyuv_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import rgbyuv_pkg::*;

    localparam int MAX_DIM     = 4096;
    localparam int HOLD_CYCLES = 60;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_LIMIT = 40;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} traffic_t;

    // Block inputs start from known values; all later changes happen at rising edges.
    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_write   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;
    logic                   pixel_valid = 1'b0;
    logic                   pixel_stall;
    pix_t                   pixel       = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    res_t                   result;

    // Traffic shaping and the long receiver hold-off
    int          sender_idle_pct = 0;
    int          stall_pct       = 0;
    logic        hold_stall      = 1'b0;
    event        start_hold;
    int unsigned cycle_count     = 0;
    int          mismatch_count  = 0;

    // Converter state as the predictor sees it
    logic [12:0]             width_reg;
    logic [12:0]             height_reg;
    logic                    layout_reg;
    logic                    round_reg;
    int unsigned             frame_w;
    int unsigned             frame_h;
    int unsigned             frame_pixels;
    int unsigned             column_pos;
    int unsigned             row_pos;
    logic [LUMA_ADDR_W-1:0]  luma_next;
    logic [CHROMA_CNT_W-1:0] chroma_next;

    // Expected YUV results, oldest first
    res_t pending_results[$];

    // Black, white, primaries, secondaries and mid gray
    logic [23:0] corner_colors [9] = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                                       24'h0000FF, 24'h00FFFF, 24'hFF00FF, 24'hFFFF00,
                                       24'h808080};

    rgb_to_yuv420_converter DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #6 clk = ~clk;

    // Abort a run that stops making progress.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("rgb_to_yuv420_converter: mismatch");
            $finish;
        end
    end

    // Receiver: stall at random, or hold off completely while a hold-off runs.
    always @(posedge clk)
        result_stall <= hold_stall || ($urandom_range(99) < stall_pct);

    // Long hold-off: count the cycles here so the sender keeps offering requests meanwhile.
    initial
    begin
        forever
        begin
            @(start_hold);
            hold_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_stall <= 1'b0;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got 0x%0h, want 0x%0h", name, got, want));
    endtask

    // Compare every taken result with the oldest expectation.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result taken with no expectation pending");
            else
            begin
                want = pending_results.pop_front();
                check_field("luma_value", result.luma_value, want.luma_value);
                check_field("luma_address", result.luma_address, want.luma_address);
                check_field("chroma_valid", result.chroma_valid, want.chroma_valid);
                check_field("blue_diff_value", result.blue_diff_value, want.blue_diff_value);
                check_field("red_diff_value", result.red_diff_value, want.red_diff_value);
                check_field("blue_diff_address", result.blue_diff_address,
                            want.blue_diff_address);
                check_field("red_diff_address", result.red_diff_address,
                            want.red_diff_address);
                check_field("frame_end", result.frame_end, want.frame_end);
            end
        end
    end

    // Clamp the size to the supported range and round down to even.
    function automatic int unsigned fit_dimension(input logic [12:0] raw);
        int unsigned v;
        v = raw;
        if (v < 2)
            v = 2;
        if (v > MAX_DIM)
            v = MAX_DIM;
        return v & 32'hFFFF_FFFE;
    endfunction

    // Recompute the frame geometry and restart at the first pixel.
    function automatic void restart_frame();
        frame_w      = fit_dimension(width_reg);
        frame_h      = fit_dimension(height_reg);
        frame_pixels = frame_w * frame_h;
        column_pos   = 0;
        row_pos      = 0;
        luma_next    = '0;
        chroma_next  = '0;
    endfunction

    function automatic void reset_converter_model();
        width_reg  = RESET_WIDTH;
        height_reg = RESET_HEIGHT;
        layout_reg = RESET_LAYOUT;
        round_reg  = RESET_ROUNDING;
        restart_frame();
    endfunction

    // Q8 sum to byte: optional rounding, floor shift, offset, clamp to 0..255.
    function automatic logic [7:0] clamp_byte(input int sum, input int offset);
        int v;
        v = ((sum + 32768 + (round_reg ? 128 : 0)) >>> 8) - 128 + offset;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    // Convert one pixel and advance the raster position.
    function automatic res_t predict_yuv(input pix_t p);
        res_t r;
        int   red;
        int   green;
        int   blue;
        logic take_chroma;
        logic frame_done;
        red         = p.red;
        green       = p.green;
        blue        = p.blue;
        take_chroma = !row_pos[0] && !column_pos[0];
        frame_done  = (column_pos + 1 >= frame_w) && (row_pos + 1 >= frame_h);
        r = '0;
        r.luma_value   = clamp_byte(66 * red + 129 * green + 25 * blue, 16);
        r.luma_address = luma_next;
        r.chroma_valid = take_chroma;
        if (take_chroma)
        begin
            r.blue_diff_value = clamp_byte(-38 * red - 74 * green + 112 * blue, 128);
            r.red_diff_value  = clamp_byte(112 * red - 94 * green - 18 * blue, 128);
            if (layout_reg == LAYOUT_I420)
            begin
                r.blue_diff_address = CHROMA_ADDR_W'(frame_pixels + chroma_next);
                r.red_diff_address  = CHROMA_ADDR_W'(frame_pixels + frame_pixels / 4
                                                     + chroma_next);
            end
            else
            begin
                r.blue_diff_address = CHROMA_ADDR_W'(frame_pixels + 2 * chroma_next);
                r.red_diff_address  = CHROMA_ADDR_W'(frame_pixels + 2 * chroma_next + 1);
            end
            chroma_next = chroma_next + 1'b1;
        end
        r.frame_end = frame_done;
        if (frame_done)
        begin
            column_pos  = 0;
            row_pos     = 0;
            luma_next   = '0;
            chroma_next = '0;
        end
        else
        begin
            luma_next = luma_next + 1'b1;
            if (column_pos + 1 >= frame_w)
            begin
                column_pos = 0;
                row_pos++;
            end
            else
                column_pos++;
        end
        return r;
    endfunction

    // Random pixel, with each component pinned to 0 or 255 now and then.
    function automatic pix_t random_pixel();
        pix_t p;
        p = 24'($urandom);
        if ($urandom_range(7) == 0)
            p.red = $urandom_range(1) ? 8'hFF : 8'h00;
        if ($urandom_range(7) == 0)
            p.green = $urandom_range(1) ? 8'hFF : 8'h00;
        if ($urandom_range(7) == 0)
            p.blue = $urandom_range(1) ? 8'hFF : 8'h00;
        return p;
    endfunction

    task automatic set_traffic(input traffic_t mode);
        case (mode)
            IDLE_NONE:     begin sender_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin sender_idle_pct = 83; stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_idle_pct = 0;  stall_pct = 83; end
            default:       begin sender_idle_pct = 34; stall_pct = 34; end
        endcase
    endtask

    // Offer one pixel request, hold it until taken, then log its expected result.
    task automatic send_pixel(input pix_t value);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= value;
        do
            @(posedge clk);
        while (pixel_stall);
        pending_results.push_back(predict_yuv(value));
    endtask

    // Drop valid and wait until every expected result has been taken.
    task automatic settle_block();
        pixel_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register while the block is idle; mirror it in the model.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:
            begin
                width_reg = value;
                restart_frame();
            end
            REG_IMAGE_HEIGHT:
            begin
                height_reg = value;
                restart_frame();
            end
            REG_CHROMA_LAYOUT:   layout_reg = value[0];
            REG_ROUNDING_ENABLE: round_reg = value[0];
        endcase
    endtask

    // Flag registers only look at bit 0; fill the rest with noise.
    task automatic write_flags(input logic layout, input logic round_on);
        write_register(REG_CHROMA_LAYOUT, {12'($urandom), layout});
        write_register(REG_ROUNDING_ENABLE, {12'($urandom), round_on});
    endtask

    // Reset register values: 720 x 1280, NV12, rounding on.
    task automatic test_reset_defaults();
        int i;
        set_traffic(IDLE_NONE);
        for (i = 0; i < 3; i++)
            send_pixel(corner_colors[i % 2 == 0 ? 0 : 1]);
        settle_block();
    endtask

    // Color extremes on a 2 x 2 frame, both layouts, rounding on and off.
    // Counters keep running across the flag writes.
    task automatic test_corner_colors();
        int i;
        set_traffic(IDLE_NONE);
        write_register(REG_IMAGE_WIDTH, 13'd2);
        write_register(REG_IMAGE_HEIGHT, 13'd2);
        write_flags(LAYOUT_NV12, 1'b1);
        for (i = 0; i < 9; i++)
            send_pixel(corner_colors[i]);
        settle_block();
        write_flags(LAYOUT_I420, 1'b0);
        for (i = 0; i < 9; i++)
            send_pixel(corner_colors[8 - i]);
        settle_block();
    endtask

    // Sizes below 2, odd sizes and sizes past the maximum.
    task automatic test_size_limits();
        logic [12:0] widths  [6] = '{13'd0, 13'd1, 13'd8191, 13'd4097, 13'd4096, 13'd3};
        logic [12:0] heights [6] = '{13'd0, 13'd1, 13'd8191, 13'd4095, 13'd3, 13'd4096};
        int i;
        int j;
        set_traffic(IDLE_BOTH);
        for (i = 0; i < 6; i++)
        begin
            write_register(REG_IMAGE_WIDTH, widths[i]);
            write_register(REG_IMAGE_HEIGHT, heights[i]);
            write_flags(logic'(i % 2), logic'(i / 3));
            for (j = 0; j < 6; j++)
                send_pixel(random_pixel());
            settle_block();
        end
    endtask

    // Random pixels over random frame sizes, cycling through the traffic modes.
    // Mostly small frames so frame ends come often; flags change mid-frame.
    task automatic test_random_traffic();
        int phase;
        int half;
        int i;
        for (phase = 0; phase < 8; phase++)
        begin
            set_traffic(traffic_t'(phase % 4));
            if ($urandom_range(3) == 0)
                write_register(REG_IMAGE_WIDTH, 13'($urandom_range(0, 8191)));
            else
                write_register(REG_IMAGE_WIDTH, 13'($urandom_range(0, 21)));
            write_register(REG_IMAGE_HEIGHT, 13'($urandom_range(0, 11)));
            for (half = 0; half < 2; half++)
            begin
                write_flags(logic'($urandom_range(1)), logic'($urandom_range(1)));
                for (i = 0; i < 60; i++)
                    send_pixel(random_pixel());
                settle_block();
            end
        end
    endtask

    // Hold the receiver off for a long stretch while pixels keep coming,
    // so the queue fills and the input side stalls.
    task automatic test_hold_off();
        int i;
        set_traffic(IDLE_NONE);
        write_register(REG_IMAGE_WIDTH, 13'd4);
        write_register(REG_IMAGE_HEIGHT, 13'd4);
        write_flags(LAYOUT_I420, 1'b1);
        -> start_hold;
        for (i = 0; i < 40; i++)
            send_pixel(random_pixel());
        settle_block();
    endtask

    initial
    begin
        reset_converter_model();
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_corner_colors();
        test_size_limits();
        test_random_traffic();
        test_hold_off();

        settle_block();
        if (mismatch_count == 0)
            $display("rgb_to_yuv420_converter: match");
        else
            $display("rgb_to_yuv420_converter: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
design/rgbyuv_pkg.sv
design/rgbyuv_front.sv
design/rgbyuv_queue.sv
design/rgbyuv_back.sv
design/rgb_to_yuv420_converter.sv
design/rgbyuv_checker.sv
test/tb_top.sv
